FILE: sv/expression_char_tokenizer_macros.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef EXPRESSION_CHAR_TOKENIZER_MACROS_SVH
`define EXPRESSION_CHAR_TOKENIZER_MACROS_SVH

`ifndef SYNTHESIS
`define ECT_ASSERT_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("tokenizer check failed");
`define ECT_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("tokenizer check failed");
`else
`define ECT_ASSERT_IMPLY(lbl, ck, rs, ante, cons)
`define ECT_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif

`endif

FILE: sv/ect_pkg.sv
// Types, constants and limits shared by the tokenizer modules.
`default_nettype none
package ect_pkg;

  localparam int MAX_DIGITS = 18;
  localparam int SIG_W      = 60;
  localparam int FRAC_W     = 5;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  function automatic logic [63:0] calc_limit();
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < MAX_DIGITS && i < 19; i++) begin
      p = p * 64'd10;
    end
    p = p - 64'd1;
    if (p > {{(64 - SIG_W){1'b0}}, {SIG_W{1'b1}}}) begin
      p = {{(64 - SIG_W){1'b0}}, {SIG_W{1'b1}}};
    end
    return p;
  endfunction

  localparam logic [SIG_W-1:0]  SIG_LIMIT = SIG_W'(calc_limit());
  localparam logic [SIG_W-1:0]  LIM_DIV10 = SIG_LIMIT / 10;
  localparam logic [FRAC_W-1:0] FRAC_CAP  =
    FRAC_W'((MAX_DIGITS > 19) ? 19 : ((MAX_DIGITS < 0) ? 0 : MAX_DIGITS));

  typedef enum logic [3:0] {
    TK_NUMBER = 4'd0,
    TK_PLUS   = 4'd1,
    TK_MINUS  = 4'd2,
    TK_MUL    = 4'd3,
    TK_DIV    = 4'd4,
    TK_POW    = 4'd5,
    TK_LPAREN = 4'd6,
    TK_RPAREN = 4'd7,
    TK_SIN    = 4'd8,
    TK_COS    = 4'd9,
    TK_TAN    = 4'd10,
    TK_SQRT   = 4'd11,
    TK_LOG    = 4'd12,
    TK_LN     = 4'd13,
    TK_EQUALS = 4'd14,
    TK_VAR    = 4'd15
  } ect_kind_t;

  localparam logic [1:0] VAR_X = 2'd0;
  localparam logic [1:0] VAR_Y = 2'd1;
  localparam logic [1:0] VAR_Z = 2'd2;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_Y      = 8'h79;
  localparam logic [7:0] CH_Z      = 8'h7A;

  typedef struct packed {
    ect_kind_t         kind;
    logic [SIG_W-1:0]  significand;
    logic [FRAC_W-1:0] fraction_digits;
    logic              number_overflow;
    logic [1:0]        variable_id;
    logic              last_of_run;
  } ect_token_t;

  typedef struct packed {
    logic [1:0] count;
    ect_token_t first;
    ect_token_t second;
  } ect_push_t;

endpackage
`default_nettype wire

FILE: sv/ect_char_if.sv
// Character input channel: valid/ready handshake with one character.
`default_nettype none
interface ect_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, char_code, end_of_text, input ready);
  modport sink   (input valid, char_code, end_of_text, output ready);
endinterface
`default_nettype wire

FILE: sv/ect_token_if.sv
// Token output channel: valid/ready handshake with one token.
`default_nettype none
interface ect_token_if
  import ect_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [3:0]        token_kind;
  logic [SIG_W-1:0]  significand;
  logic [FRAC_W-1:0] fraction_digits;
  logic              number_overflow;
  logic [1:0]        variable_id;
  logic              last_of_run;

  modport source (output valid, token_kind, significand, fraction_digits, number_overflow,
                  variable_id, last_of_run, input ready);
  modport sink   (input valid, token_kind, significand, fraction_digits, number_overflow,
                  variable_id, last_of_run, output ready);
endinterface
`default_nettype wire

FILE: sv/expression_char_tokenizer.sv
// Expression tokenizer: one character per transaction in, one token per transaction out.
// The block takes one character per cycle into an input register while the queue has room,
// and the keyword prefix machine and the number accumulator (a multiply by ten as two shifts
// and an add, checked against the significand limit) decide its tokens, at most two: a
// closing number and then an operator, variable or keyword. Those go into a four-entry
// result queue, which sends one token per cycle while the receiver is ready. An accepted
// character passes through the input register and the queue before its first token appears.
// Throughput is one character per cycle while each character yields at most one token; one
// that yields two holds the output port for both, which sets the sustained rate. A number is
// closed by the character that follows it or by end_of_text, which returns all state to reset.
`default_nettype none
module expression_char_tokenizer
  import ect_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  ect_char_if.sink    chars,
  ect_token_if.source tokens
);

  ect_push_t  push;
  logic       room;
  ect_token_t head;

  ect_core u_core (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (chars.valid),
    .char_code   (chars.char_code),
    .end_of_text (chars.end_of_text),
    .in_ready    (chars.ready),
    .room        (room),
    .push        (push)
  );

  ect_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (tokens.valid),
    .out_ready (tokens.ready),
    .head      (head)
  );

  assign tokens.token_kind      = head.kind;
  assign tokens.significand     = head.significand;
  assign tokens.fraction_digits = head.fraction_digits;
  assign tokens.number_overflow = head.number_overflow;
  assign tokens.variable_id     = head.variable_id;
  assign tokens.last_of_run     = head.last_of_run;

endmodule
`default_nettype wire

FILE: sv/ect_fifo.sv
// Result queue: takes up to two tokens a cycle, hands out one a cycle while out_ready is high.
`default_nettype none
`include "expression_char_tokenizer_macros.svh"
module ect_fifo
  import ect_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire ect_push_t  push,
  output logic            room,
  output logic            out_valid,
  input  wire logic       out_ready,
  output ect_token_t      head
);

  ect_token_t           mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr;
  logic [FIFO_AW-1:0]   wr_plus1;
  logic [FIFO_AW-1:0]   rd;
  logic [FIFO_CW-1:0]   count;
  logic                 pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign head      = mem[rd];
  assign room      = (count <= FIFO_CW'(FIFO_DEPTH - 2));
  assign wr_plus1  = wr + 1'b1;

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_plus1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      wr    <= wr + FIFO_AW'(push.count);
      rd    <= rd + FIFO_AW'(pop);
      count <= count + FIFO_CW'(push.count) - FIFO_CW'(pop);
    end
  end

  `ECT_ASSERT_IMPLY(a_fifo_no_overrun, clk, rst, push.count != 2'd0,
                    (32'(count) + 32'(push.count)) <= FIFO_DEPTH)
  `ECT_ASSERT_NEXT(a_fifo_pop_frees, clk, rst, pop && push.count == 2'd0,
                   count == $past(count) - FIFO_CW'(1))

endmodule
`default_nettype wire

FILE: sv/ect_core.sv
// Input register, keyword prefix machine and number accumulator.
`default_nettype none
`include "expression_char_tokenizer_macros.svh"
module ect_core
  import ect_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [7:0] char_code,
  input  wire logic       end_of_text,
  output logic            in_ready,
  input  wire logic       room,
  output ect_push_t       push
);

  typedef enum logic [10:0] {
    PFX_IDLE = 11'b000_0000_0001,
    PFX_S    = 11'b000_0000_0010,
    PFX_SI   = 11'b000_0000_0100,
    PFX_SQ   = 11'b000_0000_1000,
    PFX_SQR  = 11'b000_0001_0000,
    PFX_L    = 11'b000_0010_0000,
    PFX_LO   = 11'b000_0100_0000,
    PFX_C    = 11'b000_1000_0000,
    PFX_CO   = 11'b001_0000_0000,
    PFX_T    = 11'b010_0000_0000,
    PFX_TA   = 11'b100_0000_0000
  } pfx_t;

  localparam logic [1:0] PT_INT  = 2'd0;
  localparam logic [1:0] PT_FRAC = 2'd1;
  localparam logic [1:0] PT_DROP = 2'd2;

  typedef struct packed {
    logic              active;
    logic [SIG_W-1:0]  value;
    logic [FRAC_W-1:0] frac;
    logic [1:0]        pc;
    logic              ovf;
  } num_t;

  function automatic num_t add_digit(num_t cur, logic [3:0] d);
    num_t        r;
    logic [63:0] v10;
    logic [63:0] sum;
    logic        fits;
    r    = cur;
    v10  = ({{(64 - SIG_W){1'b0}}, cur.value} << 3) + ({{(64 - SIG_W){1'b0}}, cur.value} << 1);
    sum  = v10 + 64'(d);
    fits = (cur.value <= LIM_DIV10) && (sum <= 64'(SIG_LIMIT));
    if (cur.pc == PT_INT) begin
      if (fits) begin
        r.value = SIG_W'(sum);
      end else begin
        r.value = SIG_LIMIT;
        r.ovf   = 1'b1;
      end
    end else if (cur.pc == PT_FRAC) begin
      if (fits && cur.frac < FRAC_CAP) begin
        r.value = SIG_W'(sum);
        r.frac  = cur.frac + 1'b1;
      end else begin
        r.pc = PT_DROP;
      end
    end
    return r;
  endfunction

  logic       a_valid;
  logic [7:0] a_char;
  logic       a_eot;
  pfx_t       prefix;
  pfx_t       prefix_next;
  num_t       num;
  num_t       num_mid;
  num_t       num_next;
  num_t       num_src;

  logic       fire;
  logic       is_dig;
  logic [3:0] dval;
  logic [7:0] lc;
  logic       kw_hit;
  ect_kind_t  kw_kind;
  pfx_t       kw_next;
  logic       continued;
  logic       fresh;
  logic       close_num;
  logic       eot_num;
  logic       has_num;
  logic       tok_hit;
  ect_kind_t  tok_kind;
  logic [1:0] tok_var;
  ect_token_t num_tok;
  ect_token_t sym_tok;

  assign fire     = a_valid && room;
  assign in_ready = !a_valid || room;
  assign is_dig   = (a_char >= 8'h30) && (a_char <= 8'h39);
  assign dval     = a_char[3:0];
  assign lc       = ((a_char >= 8'h41) && (a_char <= 8'h5A)) ? (a_char | 8'h20) : a_char;

  always_comb begin
    kw_hit  = 1'b0;
    kw_kind = TK_SIN;
    kw_next = PFX_IDLE;
    unique case (prefix)
      PFX_S: begin
        if (lc == "i") kw_next = PFX_SI;
        else if (lc == "q") kw_next = PFX_SQ;
      end
      PFX_SI:  if (lc == "n") begin kw_hit = 1'b1; kw_kind = TK_SIN; end
      PFX_SQ:  if (lc == "r") kw_next = PFX_SQR;
      PFX_SQR: if (lc == "t") begin kw_hit = 1'b1; kw_kind = TK_SQRT; end
      PFX_L: begin
        if (lc == "n") begin
          kw_hit  = 1'b1;
          kw_kind = TK_LN;
        end else if (lc == "o") begin
          kw_next = PFX_LO;
        end
      end
      PFX_LO:  if (lc == "g") begin kw_hit = 1'b1; kw_kind = TK_LOG; end
      PFX_C:   if (lc == "o") kw_next = PFX_CO;
      PFX_CO:  if (lc == "s") begin kw_hit = 1'b1; kw_kind = TK_COS; end
      PFX_T:   if (lc == "a") kw_next = PFX_TA;
      PFX_TA:  if (lc == "n") begin kw_hit = 1'b1; kw_kind = TK_TAN; end
      default: ;
    endcase
  end

  assign continued = (prefix != PFX_IDLE) && (kw_hit || kw_next != PFX_IDLE);

  always_comb begin
    num_mid     = num;
    prefix_next = prefix;
    close_num   = 1'b0;
    fresh       = 1'b0;
    tok_hit     = 1'b0;
    tok_kind    = TK_PLUS;
    tok_var     = VAR_X;

    if (num.active) begin
      if (is_dig) begin
        num_mid = add_digit(num, dval);
      end else if (a_char == CH_POINT) begin
        if (num.pc != PT_DROP) num_mid.pc = num.pc + 1'b1;
      end else begin
        close_num = 1'b1;
        num_mid   = '0;
        fresh     = 1'b1;
      end
    end else begin
      fresh = 1'b1;
    end

    if (fresh) begin
      if (continued) begin
        prefix_next = kw_next;
        tok_hit     = kw_hit;
        tok_kind    = kw_kind;
      end else begin
        prefix_next = PFX_IDLE;
        if (is_dig) begin
          num_mid        = '0;
          num_mid.active = 1'b1;
          num_mid.value  = SIG_W'(dval);
        end else begin
          tok_hit = 1'b1;
          case (a_char)
            CH_PLUS:   tok_kind = TK_PLUS;
            CH_MINUS:  tok_kind = TK_MINUS;
            CH_STAR:   tok_kind = TK_MUL;
            CH_SLASH:  tok_kind = TK_DIV;
            CH_CARET:  tok_kind = TK_POW;
            CH_LPAREN: tok_kind = TK_LPAREN;
            CH_RPAREN: tok_kind = TK_RPAREN;
            CH_EQUALS: tok_kind = TK_EQUALS;
            CH_X: begin tok_kind = TK_VAR; tok_var = VAR_X; end
            CH_Y: begin tok_kind = TK_VAR; tok_var = VAR_Y; end
            CH_Z: begin tok_kind = TK_VAR; tok_var = VAR_Z; end
            default: begin
              tok_hit = 1'b0;
              case (lc)
                "s":     prefix_next = PFX_S;
                "l":     prefix_next = PFX_L;
                "c":     prefix_next = PFX_C;
                "t":     prefix_next = PFX_T;
                default: prefix_next = PFX_IDLE;
              endcase
            end
          endcase
        end
      end
    end

    num_next = num_mid;
    eot_num  = a_eot && num_mid.active;
    if (a_eot) begin
      prefix_next = PFX_IDLE;
      num_next    = '0;
    end
  end

  assign has_num = close_num || eot_num;
  assign num_src = close_num ? num : num_mid;

  always_comb begin
    num_tok                 = '0;
    num_tok.kind            = TK_NUMBER;
    num_tok.significand     = num_src.value;
    num_tok.fraction_digits = num_src.frac;
    num_tok.number_overflow = num_src.ovf;
    num_tok.last_of_run     = !tok_hit;

    sym_tok             = '0;
    sym_tok.kind        = tok_kind;
    sym_tok.variable_id = tok_var;
    sym_tok.last_of_run = 1'b1;

    push.count  = fire ? (2'(has_num) + 2'(tok_hit)) : 2'd0;
    push.first  = has_num ? num_tok : sym_tok;
    push.second = sym_tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_char <= char_code;
      a_eot  <= end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix <= PFX_IDLE;
      num    <= '0;
    end else if (fire) begin
      prefix <= prefix_next;
      num    <= num_next;
    end
  end

  `ECT_ASSERT_IMPLY(a_core_prefix_excl, clk, rst, prefix != PFX_IDLE, !num.active)
  `ECT_ASSERT_IMPLY(a_core_int_nofrac, clk, rst, num.pc == PT_INT, num.frac == '0)
  `ECT_ASSERT_IMPLY(a_core_idle_clear, clk, rst, !num.active,
                    num.value == '0 && num.pc == PT_INT && !num.ovf)

endmodule
`default_nettype wire

FILE: tb/expression_char_tokenizer_tb.sv
// Self-checking testbench for the expression tokenizer: directed and random text against a token predictor.
`default_nettype none
module expression_char_tokenizer_tb;
  import ect_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_CHARS = 385;

  localparam logic [7:0] DIGIT_ZERO = "0";
  localparam logic [7:0] DIGIT_NINE = "9";
  localparam logic [7:0] CH_BLANK   = " ";
  localparam logic [7:0] UC_A       = "A";
  localparam logic [7:0] UC_Z       = "Z";
  localparam logic [7:0] CASE_BIT   = 8'h20;
  localparam logic [7:0] LC_A       = "a";
  localparam logic [7:0] LC_C       = "c";
  localparam logic [7:0] LC_G       = "g";
  localparam logic [7:0] LC_I       = "i";
  localparam logic [7:0] LC_L       = "l";
  localparam logic [7:0] LC_N       = "n";
  localparam logic [7:0] LC_O       = "o";
  localparam logic [7:0] LC_Q       = "q";
  localparam logic [7:0] LC_R       = "r";
  localparam logic [7:0] LC_S       = "s";
  localparam logic [7:0] LC_T       = "t";

  typedef enum logic [3:0] {
    PFX_IDLE, PFX_S, PFX_SI, PFX_SQ, PFX_SQR, PFX_L, PFX_LO, PFX_C, PFX_CO, PFX_T, PFX_TA
  } prefix_t;

  typedef enum logic [1:0] {PT_INTEGER, PT_FRACTION, PT_FROZEN} point_state_t;

  typedef struct {
    logic [7:0] code;
    bit         eot;
  } char_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ect_char_if  chars();
  ect_token_if tokens();

  expression_char_tokenizer dut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars),
    .tokens (tokens)
  );

  always #2 clk = ~clk;

  char_item_t pending_chars[$];
  ect_token_t expected_tokens[$];

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  bit char_taken         = 1'b0;
  int cycles             = 0;
  int chars_accepted     = 0;
  int tokens_checked     = 0;
  int numbers_seen       = 0;
  int saturated_seen     = 0;
  int mismatches         = 0;

  string      keywords[6]       = '{"sin", "cos", "tan", "sqrt", "log", "ln"};
  logic [7:0] operator_chars[8] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
                                    CH_CARET, CH_LPAREN, CH_RPAREN, CH_EQUALS};

  prefix_t           kw_prefix  = PFX_IDLE;
  bit                num_open   = 1'b0;
  logic [SIG_W-1:0]  num_digits = '0;
  logic [FRAC_W-1:0] num_frac   = '0;
  point_state_t      num_point  = PT_INTEGER;
  bit                num_ovf    = 1'b0;

  function automatic logic [7:0] lower_char(logic [7:0] c);
    return (c >= UC_A && c <= UC_Z) ? (c | CASE_BIT) : c;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= DIGIT_ZERO && c <= DIGIT_NINE;
  endfunction

  function automatic void clear_number();
    num_open   = 1'b0;
    num_digits = '0;
    num_frac   = '0;
    num_point  = PT_INTEGER;
    num_ovf    = 1'b0;
  endfunction

  function automatic void emit_token(ect_kind_t kind, logic [1:0] vid);
    ect_token_t t;
    t = '0;
    t.kind = kind;
    t.variable_id = vid;
    expected_tokens = {expected_tokens, t};
  endfunction

  function automatic void close_number();
    ect_token_t t;
    t = '0;
    t.kind = TK_NUMBER;
    t.significand = num_digits;
    t.fraction_digits = num_frac;
    t.number_overflow = num_ovf;
    expected_tokens = {expected_tokens, t};
    clear_number();
  endfunction

  function automatic void take_digit(logic [3:0] d);
    logic [63:0] lim;
    logic [63:0] acc;
    bit fits;
    lim = 64'(SIG_LIMIT);
    acc = 64'(num_digits);
    fits = (acc <= lim / 10) && (lim - acc * 10 >= 64'(d));
    case (num_point)
      PT_INTEGER: begin
        if (fits) begin
          num_digits = SIG_W'(acc * 10 + 64'(d));
        end else begin
          num_digits = SIG_LIMIT;
          num_ovf = 1'b1;
        end
      end
      PT_FRACTION: begin
        if (fits && num_frac < FRAC_CAP) begin
          num_digits = SIG_W'(acc * 10 + 64'(d));
          num_frac = num_frac + 1'b1;
        end else begin
          num_point = PT_FROZEN;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic bit step_prefix(logic [7:0] c);
    logic [7:0] lc;
    prefix_t nxt;
    bit done;
    ect_kind_t kw;
    lc = lower_char(c);
    nxt = PFX_IDLE;
    done = 1'b0;
    kw = TK_NUMBER;
    case (kw_prefix)
      PFX_S:   if (lc == LC_I) nxt = PFX_SI; else if (lc == LC_Q) nxt = PFX_SQ;
      PFX_SI:  if (lc == LC_N) begin done = 1'b1; kw = TK_SIN; end
      PFX_SQ:  if (lc == LC_R) nxt = PFX_SQR;
      PFX_SQR: if (lc == LC_T) begin done = 1'b1; kw = TK_SQRT; end
      PFX_L:   if (lc == LC_N) begin done = 1'b1; kw = TK_LN; end
               else if (lc == LC_O) nxt = PFX_LO;
      PFX_LO:  if (lc == LC_G) begin done = 1'b1; kw = TK_LOG; end
      PFX_C:   if (lc == LC_O) nxt = PFX_CO;
      PFX_CO:  if (lc == LC_S) begin done = 1'b1; kw = TK_COS; end
      PFX_T:   if (lc == LC_A) nxt = PFX_TA;
      PFX_TA:  if (lc == LC_N) begin done = 1'b1; kw = TK_TAN; end
      default: ;
    endcase
    if (done) begin
      emit_token(kw, VAR_X);
      kw_prefix = PFX_IDLE;
      return 1'b1;
    end
    kw_prefix = nxt;
    return nxt != PFX_IDLE;
  endfunction

  function automatic void fresh_char(logic [7:0] c);
    logic [7:0] lc;
    if (kw_prefix != PFX_IDLE && step_prefix(c)) return;
    kw_prefix = PFX_IDLE;
    if (is_digit(c)) begin
      clear_number();
      num_open = 1'b1;
      take_digit(4'(c - DIGIT_ZERO));
      return;
    end
    case (c)
      CH_PLUS:   emit_token(TK_PLUS, VAR_X);
      CH_MINUS:  emit_token(TK_MINUS, VAR_X);
      CH_STAR:   emit_token(TK_MUL, VAR_X);
      CH_SLASH:  emit_token(TK_DIV, VAR_X);
      CH_CARET:  emit_token(TK_POW, VAR_X);
      CH_LPAREN: emit_token(TK_LPAREN, VAR_X);
      CH_RPAREN: emit_token(TK_RPAREN, VAR_X);
      CH_EQUALS: emit_token(TK_EQUALS, VAR_X);
      CH_X:      emit_token(TK_VAR, VAR_X);
      CH_Y:      emit_token(TK_VAR, VAR_Y);
      CH_Z:      emit_token(TK_VAR, VAR_Z);
      default: begin
        lc = lower_char(c);
        if (lc == LC_S) kw_prefix = PFX_S;
        else if (lc == LC_L) kw_prefix = PFX_L;
        else if (lc == LC_C) kw_prefix = PFX_C;
        else if (lc == LC_T) kw_prefix = PFX_T;
      end
    endcase
  endfunction

  function automatic void tokenize_char(logic [7:0] c, bit eot);
    int first_idx;
    first_idx = expected_tokens.size();
    if (num_open) begin
      if (is_digit(c)) begin
        take_digit(4'(c - DIGIT_ZERO));
      end else if (c == CH_POINT) begin
        if (num_point != PT_FROZEN) num_point = point_state_t'(num_point + 1'b1);
      end else begin
        close_number();
        fresh_char(c);
      end
    end else begin
      fresh_char(c);
    end
    if (eot) begin
      if (num_open) close_number();
      kw_prefix = PFX_IDLE;
      clear_number();
    end
    if (expected_tokens.size() > first_idx)
      expected_tokens[expected_tokens.size() - 1].last_of_run = 1'b1;
  endfunction

  function automatic string token_text(ect_token_t t);
    return $sformatf("kind %0d sig %0d frac %0d ovf %0d var %0d last %0d", t.kind,
                     t.significand, t.fraction_digits, t.number_overflow, t.variable_id,
                     t.last_of_run);
  endfunction

  function automatic void report_mismatch(string what);
    if (mismatches < 10) $display("MISMATCH at cycle %0d: %s", cycles, what);
    mismatches++;
  endfunction

  function automatic void push_char(logic [7:0] c, bit eot);
    char_item_t item;
    item.code = c;
    item.eot = eot;
    pending_chars = {pending_chars, item};
  endfunction

  function automatic bit random_eot();
    return $urandom_range(63) == 0;
  endfunction

  function automatic void add_fragment();
    int pick;
    int n;
    int len;
    string kw;
    logic [7:0] c;
    pick = $urandom_range(99);
    if (pick < 30) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 5);
      repeat (n) push_char(8'(DIGIT_ZERO + $urandom_range(9)), random_eot());
      if ($urandom_range(1)) begin
        push_char(CH_POINT, random_eot());
        n = ($urandom_range(7) == 0) ? $urandom_range(15, 22) : $urandom_range(0, 4);
        repeat (n) push_char(8'(DIGIT_ZERO + $urandom_range(9)), random_eot());
        if ($urandom_range(5) == 0) begin
          push_char(CH_POINT, random_eot());
          repeat ($urandom_range(3)) push_char(8'(DIGIT_ZERO + $urandom_range(9)), random_eot());
        end
      end
    end else if (pick < 45) begin
      push_char(operator_chars[$urandom_range(7)], random_eot());
    end else if (pick < 55) begin
      push_char(8'(CH_X + $urandom_range(2)), random_eot());
    end else if (pick < 75) begin
      kw = keywords[$urandom_range(5)];
      len = kw.len();
      if ($urandom_range(3) == 0) len = $urandom_range(1, kw.len() - 1);
      for (int i = 0; i < len; i++) begin
        c = kw[i];
        if ($urandom_range(1)) c = c & ~CASE_BIT;
        push_char(c, random_eot());
      end
    end else if (pick < 85) begin
      push_char(CH_BLANK, random_eot());
    end else begin
      push_char(8'($urandom_range(255)), random_eot());
    end
  endfunction

  initial begin
    chars.valid = 1'b0;
    chars.char_code = '0;
    chars.end_of_text = 1'b0;
    tokens.ready = 1'b0;
  end

  always @(negedge clk) begin : drive_chars
    char_item_t next_item;
    if (!rst) begin
      if (!chars.valid || char_taken) begin
        if (pending_chars.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_item = pending_chars.pop_front();
          chars.valid <= 1'b1;
          chars.char_code <= next_item.code;
          chars.end_of_text <= next_item.eot;
        end else begin
          chars.valid <= 1'b0;
        end
      end
      tokens.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin : watch_ports
    ect_token_t got;
    ect_token_t want;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d tokens outstanding", cycles,
               expected_tokens.size());
      $display("expression_char_tokenizer test failed");
      $finish;
    end else if (rst) begin
      char_taken <= 1'b0;
      kw_prefix = PFX_IDLE;
      clear_number();
    end else begin
      char_taken <= chars.valid && chars.ready;
      if (tokens.valid && tokens.ready) begin
        got = '0;
        got.kind = ect_kind_t'(tokens.token_kind);
        got.significand = tokens.significand;
        got.fraction_digits = tokens.fraction_digits;
        got.number_overflow = tokens.number_overflow;
        got.variable_id = tokens.variable_id;
        got.last_of_run = tokens.last_of_run;
        tokens_checked++;
        if (got.kind == TK_NUMBER) numbers_seen++;
        if (got.number_overflow) saturated_seen++;
        if (expected_tokens.size() == 0) begin
          report_mismatch({"unexpected token: ", token_text(got)});
        end else begin
          want = expected_tokens.pop_front();
          if (got !== want)
            report_mismatch({"expected ", token_text(want), " got ", token_text(got)});
        end
      end
      if (chars.valid && chars.ready) begin
        chars_accepted++;
        tokenize_char(chars.char_code, chars.end_of_text);
      end
    end
  end

  initial begin : stimulus
    string opening;
    int queued;
    opening = "SIN(x)-sqrt*cOs/tan^log+ln=.lz9.1.2";
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    push_char(8'h00, 1'b0);
    for (int i = 0; i < opening.len(); i++) push_char(opening[i], 1'b0);
    push_char(8'hFF, 1'b1);
    push_char(LC_S, 1'b1);
    while (pending_chars.size() != 0) @(posedge clk);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 74; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 74; end
        default: begin sender_idle_pct = 28; receiver_stall_pct = 28; end
      endcase
      queued = 0;
      while (queued < PHASE_CHARS) begin
        add_fragment();
        queued = pending_chars.size();
      end
      while (pending_chars.size() != 0) @(posedge clk);
    end
    push_char(CH_BLANK, 1'b1);

    while (pending_chars.size() != 0 || chars.valid) @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Fed %0d characters (directed opening, then four stall patterns); %0d tokens checked,",
             chars_accepted, tokens_checked);
    $display("%0d of them numbers with %0d saturated; %0d mismatches, %0d tokens missing",
             numbers_seen, saturated_seen, mismatches, expected_tokens.size());
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("expression_char_tokenizer test passed");
    end else begin
      $display("expression_char_tokenizer test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
+incdir+sv
sv/ect_pkg.sv
sv/ect_char_if.sv
sv/ect_token_if.sv
sv/ect_fifo.sv
sv/ect_core.sv
sv/expression_char_tokenizer.sv
tb/expression_char_tokenizer_tb.sv
